FILE: rtl/adam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam update package
// Shared widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package adam_pkg;

	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 24;

	// configuration registers
	localparam int REG_WIDTH       = 25;
	localparam int REG_INDEX_WIDTH = 3;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_BETA_ONE      = 3'd1,
		REG_BETA_TWO      = 3'd2,
		REG_EPSILON_TERM  = 3'd3,
		REG_BIAS_ONE      = 3'd4,
		REG_BIAS_TWO      = 3'd5
	} reg_index_t;

	localparam logic [REG_WIDTH-1:0] LEARNING_RATE_RST = 25'd16777;
	localparam logic [REG_WIDTH-1:0] BETA_ONE_RST      = 25'd15099494;
	localparam logic [REG_WIDTH-1:0] BETA_TWO_RST      = 25'd16760439;
	localparam logic [REG_WIDTH-1:0] EPSILON_TERM_RST  = 25'd1;
	localparam logic [REG_WIDTH-1:0] BIAS_ONE_RST      = 25'd16777216;
	localparam logic [REG_WIDTH-1:0] BIAS_TWO_RST      = 25'd16777216;

endpackage

FILE: rtl/adam_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam input channel
// One element per transaction: parameter, gradient and both moments.
// ----------------------------------------------------------------------------
interface adam_in_if import adam_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] param_in;
	logic signed [VALUE_WIDTH-1:0] grad_in;
	logic signed [VALUE_WIDTH-1:0] moment_one_in;
	logic        [VALUE_WIDTH-2:0] moment_two_in;

	modport source (output valid, param_in, grad_in, moment_one_in, moment_two_in,
		input ready);
	modport sink (input valid, param_in, grad_in, moment_one_in, moment_two_in,
		output ready);
endinterface

FILE: rtl/adam_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam output channel
// One updated element per transaction plus the saturation flag.
// ----------------------------------------------------------------------------
interface adam_out_if import adam_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] new_param;
	logic signed [VALUE_WIDTH-1:0] new_moment_one;
	logic        [VALUE_WIDTH-2:0] new_moment_two;
	logic                          saturated;

	modport source (output valid, new_param, new_moment_one, new_moment_two, saturated,
		input ready);
	modport sink (input valid, new_param, new_moment_one, new_moment_two, saturated,
		output ready);
endinterface

FILE: rtl/adam_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam divider cell
// One restoring division step: shift in a numerator bit, subtract if it fits.
// ----------------------------------------------------------------------------
module adam_div_cell import adam_pkg::*; #(
	parameter int NW = 56,
	parameter int DW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [NW-1:0] nq_i,
	input  logic [DW-1:0] rem_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [NW-1:0] nq_o,
	output logic [DW-1:0] rem_o,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;
	logic          vld_q;
	logic [NW-1:0] nq_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [SW-1:0] side_q;

	assign trial = {rem_i, nq_i[NW-1]};
	assign fits  = trial >= {1'b0, den_i};
	assign diff  = trial - {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// quotient bits shift in from the bottom as numerator bits leave the top
	always_ff @(posedge clk) begin
		if (en) begin
			nq_q   <= {nq_i[NW-2:0], fits};
			rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
			den_q  <= den_i;
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign nq_o   = nq_q;
	assign rem_o  = rem_q;
	assign den_o  = den_q;
	assign side_o = side_q;
endmodule

FILE: rtl/adam_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam divider chain
// NW cells in a row, one quotient bit each, unsigned truncating division.
// ----------------------------------------------------------------------------
module adam_div_chain import adam_pkg::*; #(
	parameter int NW = 56,
	parameter int DW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [NW-1:0] quo_o,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);
	logic          vld_w  [0:NW];
	logic [NW-1:0] nq_w   [0:NW];
	logic [DW-1:0] rem_w  [0:NW];
	logic [DW-1:0] den_w  [0:NW];
	logic [SW-1:0] side_w [0:NW];

	assign vld_w[0]  = vld_i;
	assign nq_w[0]   = num_i;
	assign rem_w[0]  = '0;
	assign den_w[0]  = den_i;
	assign side_w[0] = side_i;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		adam_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_w[i]),
			.nq_i   (nq_w[i]),
			.rem_i  (rem_w[i]),
			.den_i  (den_w[i]),
			.side_i (side_w[i]),
			.vld_o  (vld_w[i+1]),
			.nq_o   (nq_w[i+1]),
			.rem_o  (rem_w[i+1]),
			.den_o  (den_w[i+1]),
			.side_o (side_w[i+1])
		);
	end

	assign vld_o  = vld_w[NW];
	assign quo_o  = nq_w[NW];
	assign den_o  = den_w[NW];
	assign side_o = side_w[NW];
endmodule

FILE: rtl/adam_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam square root cell
// One digit-by-digit root step: bring down two radicand bits, try 4r+1.
// ----------------------------------------------------------------------------
module adam_sqrt_cell import adam_pkg::*; #(
	parameter int RB = 28,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RB-1:0] x_i,
	input  logic [RB:0]     rem_i,
	input  logic [RB-1:0]   root_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [2*RB-1:0] x_o,
	output logic [RB:0]     rem_o,
	output logic [RB-1:0]   root_o,
	output logic [SW-1:0]   side_o
);
	logic [RB+2:0]   cand;
	logic [RB+2:0]   trial;
	logic [RB+2:0]   diff;
	logic            fits;
	logic            vld_q;
	logic [2*RB-1:0] x_q;
	logic [RB:0]     rem_q;
	logic [RB-1:0]   root_q;
	logic [SW-1:0]   side_q;

	assign cand  = {rem_i, x_i[2*RB-1:2*RB-2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign fits  = cand >= trial;
	assign diff  = cand - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// remainder stays within twice the partial root
	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= {x_i[2*RB-3:0], 2'b00};
			rem_q  <= fits ? diff[RB:0] : cand[RB:0];
			root_q <= {root_i[RB-2:0], fits};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign x_o    = x_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;
endmodule

FILE: rtl/adam_sqrt_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam square root chain
// RB cells in a row, one root bit each, floor integer square root.
// ----------------------------------------------------------------------------
module adam_sqrt_chain import adam_pkg::*; #(
	parameter int RB = 28,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RB-1:0] x_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [RB-1:0]   root_o,
	output logic [SW-1:0]   side_o
);
	logic            vld_w  [0:RB];
	logic [2*RB-1:0] x_w    [0:RB];
	logic [RB:0]     rem_w  [0:RB];
	logic [RB-1:0]   root_w [0:RB];
	logic [SW-1:0]   side_w [0:RB];

	assign vld_w[0]  = vld_i;
	assign x_w[0]    = x_i;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign side_w[0] = side_i;

	for (genvar i = 0; i < RB; i++) begin : g_cell
		adam_sqrt_cell #(.RB(RB), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_w[i]),
			.x_i    (x_w[i]),
			.rem_i  (rem_w[i]),
			.root_i (root_w[i]),
			.side_i (side_w[i]),
			.vld_o  (vld_w[i+1]),
			.x_o    (x_w[i+1]),
			.rem_o  (rem_w[i+1]),
			.root_o (root_w[i+1]),
			.side_o (side_w[i+1])
		);
	end

	assign vld_o  = vld_w[RB];
	assign root_o = root_w[RB];
	assign side_o = side_w[RB];
endmodule

FILE: rtl/adam_optimizer_element_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam optimizer element update
// Streams one parameter element per transaction through the Adam rule.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries param, gradient and both moments; out_ch returns the new
//   param, both new moments and a saturation flag, one result per input, in
//   order. Registers (learning rate, betas, epsilon, both bias terms) are
//   written through cfg_wen/cfg_index/cfg_data. The user must write them only
//   while no element is in flight; the block itself does not enforce this.
// Throughput: one element per cycle, back to back, unless stalled.
// Pipeline order: stages 1 to 3, both bias divider chains (one quotient bit
//   per cell), stage 4, the square root chain (one root bit per cell), stage
//   5, the step size divider chain, the output register. Q8.24 by default.
// Reset: clears all valid bits and loads the register reset values.
// Stall: while out_ch holds an unaccepted result, the pipeline still
//   advances and accepts input as long as its last stage is empty; it halts
//   as a whole once a finished result sits behind the output register.
// ----------------------------------------------------------------------------
module adam_optimizer_element_update import adam_pkg::*; #(
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [REG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]       cfg_data,
	adam_in_if.sink                    in_ch,
	adam_out_if.source                 out_ch
);
	localparam int W    = VALUE_WIDTH;
	localparam int F    = FRACTION_BITS;
	localparam int CW   = F + 1;                      // clamped register, 0..1.0
	localparam int CMPW = (REG_WIDTH > CW) ? REG_WIDTH : CW;
	localparam int SMW  = CW + W + 2;                 // first moment blend sum
	localparam int GHW  = 2 * W - 2 * F;              // upper part of g*g
	localparam int VSW  = CW + 2 * W;                 // second moment blend sum
	localparam int NW   = W + F;                      // dividend width
	localparam int RB   = (W + F) / 2;                // root width
	localparam int DNW  = ((RB > CW) ? RB : CW) + 1;  // root plus epsilon
	localparam int NMW  = CW + W + 1;                 // lr * m_hat
	localparam int EW   = NW + 2;                     // param minus step

	localparam logic [CW-1:0]        ONE_C   = {1'b1, {F{1'b0}}};
	localparam logic signed [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-2:0]         MAGMAX  = {(W-1){1'b1}};
	localparam logic [NW-1:0]        HALF_N  = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [NW-1:0]        MAXN    = {{(F+1){1'b0}}, {(W-1){1'b1}}};

	typedef struct packed {
		logic signed [W-1:0] p;
		logic signed [W-1:0] m1;
		logic                neg;
	} mside_t;

	typedef struct packed {
		logic [W-2:0] v1;
		logic         flag;
	} vside_t;

	typedef struct packed {
		logic signed [W-1:0] mh;
		logic signed [W-1:0] p;
		logic signed [W-1:0] m1;
		logic [W-2:0]        v1;
		logic                flag;
	} sqside_t;

	typedef struct packed {
		logic signed [W-1:0] p;
		logic signed [W-1:0] m1;
		logic [W-2:0]        v1;
		logic                flag;
		logic                neg;
		logic                nz;
	} fside_t;

	function automatic logic [CW-1:0] clamp_one(input logic [REG_WIDTH-1:0] r);
		logic [CMPW-1:0] rx;
		rx = CMPW'(r);
		if (rx > CMPW'(ONE_C)) begin
			return ONE_C;
		end
		return rx[CW-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	logic [REG_WIDTH-1:0] lr_q, b1_q, b2_q, eps_q, bias1_q, bias2_q;
	logic [CW-1:0]        lr_c, b1_c, b2_c, eps_c, bias1_c, bias2_c;
	logic [CW-1:0]        ob1, ob2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= LEARNING_RATE_RST;
			b1_q    <= BETA_ONE_RST;
			b2_q    <= BETA_TWO_RST;
			eps_q   <= EPSILON_TERM_RST;
			bias1_q <= BIAS_ONE_RST;
			bias2_q <= BIAS_TWO_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_LEARNING_RATE: lr_q    <= cfg_data;
				REG_BETA_ONE:      b1_q    <= cfg_data;
				REG_BETA_TWO:      b2_q    <= cfg_data;
				REG_EPSILON_TERM:  eps_q   <= cfg_data;
				REG_BIAS_ONE:      bias1_q <= cfg_data;
				REG_BIAS_TWO:      bias2_q <= cfg_data;
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// clamp every register to 1.0 before use
	assign lr_c    = clamp_one(lr_q);
	assign b1_c    = clamp_one(b1_q);
	assign b2_c    = clamp_one(b2_q);
	assign eps_c   = clamp_one(eps_q);
	assign bias1_c = clamp_one(bias1_q);
	assign bias2_c = clamp_one(bias2_q);
	assign ob1     = ONE_C - b1_c;
	assign ob2     = ONE_C - b2_c;

	// ------------------------------------------------------------ flow control
	// The pipeline moves as one; it only has to halt when a finished result
	// sits in the last stage and the output register cannot take it.
	logic en;
	logic load_out;
	logic vld_f;
	logic out_valid_q;

	assign load_out    = !out_valid_q || out_ch.ready;
	assign en          = load_out || !vld_f;
	assign in_ch.ready = en;

	// -------------------------------------------------- stage 1: products
	logic signed [CW+W:0]     pm, pg;
	logic signed [2*W-1:0]    gg;
	logic        [CW+W-2:0]   pv;
	logic signed [CW+W:0]     pm_s1, pg_s1;
	logic signed [2*W-1:0]    gg_s1;
	logic        [CW+W-2:0]   pv_s1;
	logic signed [W-1:0]      p_s1;
	logic                     vld_s1;

	assign pm = $signed({1'b0, b1_c}) * in_ch.moment_one_in;
	assign pg = $signed({1'b0, ob1}) * in_ch.grad_in;
	assign gg = in_ch.grad_in * in_ch.grad_in;
	assign pv = b2_c * in_ch.moment_two_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s1 <= pm;
			pg_s1 <= pg;
			gg_s1 <= gg;
			pv_s1 <= pv;
			p_s1  <= in_ch.param_in;
		end
	end

	// ------------------------- stage 2: first moment, split g*g for the blend
	logic signed [SMW-1:0]  sum1, m1f;
	logic                   m1_fits;
	logic signed [W-1:0]    m1;
	logic        [2*W-F-1:0] g2;
	logic        [CW+F-1:0] pl;
	logic        [CW+GHW-1:0] ph;
	logic signed [W-1:0]    m1_s2, p_s2;
	logic                   flag_s2, vld_s2;
	logic        [CW+W-2:0] pv_s2;
	logic        [CW+F-1:0] pl_s2;
	logic        [CW+GHW-1:0] ph_s2;

	assign sum1    = SMW'(pm_s1) + SMW'(pg_s1);
	assign m1f     = sum1 >>> F;  // floor toward minus infinity
	assign m1_fits = (&m1f[SMW-1:W-1]) || !(|m1f[SMW-1:W-1]);
	assign m1      = m1_fits ? m1f[W-1:0] : (m1f[SMW-1] ? VMIN : VMAX);
	assign g2      = gg_s1[2*W-1:F];
	// (1-b2)*g2 split at the binary point so each product stays narrow
	assign pl      = ob2 * g2[F-1:0];
	assign ph      = ob2 * g2[2*W-F-1:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2   <= m1;
			flag_s2 <= !m1_fits;
			pv_s2   <= pv_s1;
			pl_s2   <= pl;
			ph_s2   <= ph;
			p_s2    <= p_s1;
		end
	end

	// --------------------- stage 3: second moment, form the dividends
	logic [VSW-1:0]  vs;
	logic            v1_over;
	logic [W-2:0]    v1;
	logic [W-1:0]    m1_mag;
	logic [NW-1:0]   num_m_s3, num_v_s3;
	logic [CW-1:0]   den_m_s3, den_v_s3;
	mside_t          mside_s3;
	vside_t          vside_s3;
	logic            vld_s3;

	assign vs      = ((VSW'(pv_s2) + VSW'(pl_s2)) >> F) + VSW'(ph_s2);
	assign v1_over = vs > VSW'(MAGMAX);
	assign v1      = v1_over ? MAGMAX : vs[W-2:0];
	assign m1_mag  = m1_s2[W-1] ? (~m1_s2 + 1'b1) : m1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_m_s3      <= {m1_mag, {F{1'b0}}};
			num_v_s3      <= {1'b0, v1, {F{1'b0}}};
			den_m_s3      <= bias1_c;
			den_v_s3      <= bias2_c;
			mside_s3.p    <= p_s2;
			mside_s3.m1   <= m1_s2;
			mside_s3.neg  <= m1_s2[W-1];
			vside_s3.v1   <= v1;
			vside_s3.flag <= flag_s2 || v1_over;
		end
	end

	// ---------------------------- bias correction: two division chains
	logic          vld_mc, vld_vc;
	logic [NW-1:0] qm, qv;
	logic [CW-1:0] den_mc, den_vc;
	mside_t        mside_c;
	vside_t        vside_c;

	adam_div_chain #(.NW(NW), .DW(CW), .SW($bits(mside_t))) u_div_m (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.num_i  (num_m_s3),
		.den_i  (den_m_s3),
		.side_i (mside_s3),
		.vld_o  (vld_mc),
		.quo_o  (qm),
		.den_o  (den_mc),
		.side_o (mside_c)
	);

	adam_div_chain #(.NW(NW), .DW(CW), .SW($bits(vside_t))) u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.num_i  (num_v_s3),
		.den_i  (den_v_s3),
		.side_i (vside_s3),
		.vld_o  (vld_vc),
		.quo_o  (qv),
		.den_o  (den_vc),
		.side_o (vside_c)
	);

	// ---------------- stage 4: sign, saturation and zero bias handling
	logic signed [W-1:0] mh;
	logic [W-2:0]        vh;
	logic                mh_sat, vh_sat;
	sqside_t             sqside_s4;
	logic [W-2:0]        vh_s4;
	logic                vld_s4;

	always_comb begin
		mh_sat = 1'b0;
		if (den_mc == '0) begin
			mh_sat = 1'b1;
			mh     = mside_c.neg ? VMIN : ((mside_c.m1 == '0) ? '0 : VMAX);
		end else if (mside_c.neg) begin
			mh_sat = qm > HALF_N;
			mh     = mh_sat ? VMIN : (~qm[W-1:0] + 1'b1);
		end else begin
			mh_sat = qm > MAXN;
			mh     = mh_sat ? VMAX : qm[W-1:0];
		end
	end

	always_comb begin
		vh_sat = 1'b0;
		if (den_vc == '0) begin
			vh_sat = 1'b1;
			vh     = (vside_c.v1 == '0) ? '0 : MAGMAX;
		end else begin
			vh_sat = qv > MAXN;
			vh     = vh_sat ? MAGMAX : qv[W-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_mc && vld_vc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqside_s4.mh   <= mh;
			sqside_s4.p    <= mside_c.p;
			sqside_s4.m1   <= mside_c.m1;
			sqside_s4.v1   <= vside_c.v1;
			sqside_s4.flag <= vside_c.flag || mh_sat || vh_sat;
			vh_s4          <= vh;
		end
	end

	// -------------------------------------- square root of v_hat * 2^F
	logic          vld_sq;
	logic [RB-1:0] root;
	sqside_t       sqside_c;

	adam_sqrt_chain #(.RB(RB), .SW($bits(sqside_t))) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.x_i    ((2*RB)'({vh_s4, {F{1'b0}}})),
		.side_i (sqside_s4),
		.vld_o  (vld_sq),
		.root_o (root),
		.side_o (sqside_c)
	);

	// ---------------------- stage 5: denominator and lr * m_hat
	logic signed [NMW-1:0] num;
	logic signed [NMW-1:0] num_neg;
	logic [NW-1:0]         nmag_s5;
	logic [DNW-1:0]        den_s5;
	fside_t                fside_s5;
	logic                  vld_s5;

	assign num     = $signed({1'b0, lr_c}) * sqside_c.mh;
	assign num_neg = -num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s5       <= num[NMW-1] ? num_neg[NW-1:0] : num[NW-1:0];
			den_s5        <= DNW'(root) + DNW'(eps_c);
			fside_s5.p    <= sqside_c.p;
			fside_s5.m1   <= sqside_c.m1;
			fside_s5.v1   <= sqside_c.v1;
			fside_s5.flag <= sqside_c.flag;
			fside_s5.neg  <= num[NMW-1];
			fside_s5.nz   <= num != '0;
		end
	end

	// ----------------------------------------- step size division chain
	logic [NW-1:0]  qs;
	logic [DNW-1:0] den_f;
	fside_t         fside_c;

	adam_div_chain #(.NW(NW), .DW(DNW), .SW($bits(fside_t))) u_div_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s5),
		.num_i  (nmag_s5),
		.den_i  (den_s5),
		.side_i (fside_s5),
		.vld_o  (vld_f),
		.quo_o  (qs),
		.den_o  (den_f),
		.side_o (fside_c)
	);

	// -------------------- output register: apply step, saturate, flag
	logic signed [EW-1:0] pe, qe, pdiff;
	logic                 np_fits;
	logic signed [W-1:0]  np;
	logic                 np_sat;
	logic signed [W-1:0]  new_param_q, new_moment_one_q;
	logic [W-2:0]         new_moment_two_q;
	logic                 saturated_q;

	assign pe      = EW'(fside_c.p);
	assign qe      = $signed({2'b00, qs});
	assign pdiff   = fside_c.neg ? (pe + qe) : (pe - qe);
	assign np_fits = (&pdiff[EW-1:W-1]) || !(|pdiff[EW-1:W-1]);

	always_comb begin
		if (den_f == '0) begin
			// zero denominator: saturate against the step, hold param if no step
			np_sat = 1'b1;
			np     = fside_c.nz ? (fside_c.neg ? VMAX : VMIN) : fside_c.p;
		end else begin
			np_sat = !np_fits;
			np     = np_fits ? pdiff[W-1:0] : (pdiff[EW-1] ? VMIN : VMAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= vld_f;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			new_param_q      <= np;
			new_moment_one_q <= fside_c.m1;
			new_moment_two_q <= fside_c.v1;
			saturated_q      <= fside_c.flag || np_sat;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.new_param      = new_param_q;
	assign out_ch.new_moment_one = new_moment_one_q;
	assign out_ch.new_moment_two = new_moment_two_q;
	assign out_ch.saturated      = saturated_q;

	// --------------------------------------------------------- assertions
	// both bias correction chains carry the same transactions in lockstep
	a_chain_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_mc == vld_vc)
		else $error("bias correction chains out of step");

	// a zero bias term must raise the flag for that element
	a_zero_bias_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_mc && (den_mc == '0)) |=> sqside_s4.flag)
		else $error("zero bias term did not set the flag");

	// a zero denominator must show up as saturated on the output
	a_zero_den_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && vld_f && (den_f == '0)) |=> (out_ch.valid && out_ch.saturated))
		else $error("zero denominator did not set saturated");
endmodule
